>>> hdl/pabg_pkg.sv
package pabg_pkg;

  localparam int ANG_W    = 16;
  localparam int GAIN_W   = 15;
  localparam int SPC_W    = 16;
  localparam int MASK_W   = 64;
  localparam int PHASE_W  = 16;
  localparam int Q14_W    = 16;
  localparam int D_W      = 31;
  localparam int PH_W     = 40;
  localparam int ACC_W    = 22;
  localparam int MAG_W    = 44;
  localparam int CFG_W    = 64;
  localparam int CFG_IDX_W = 1;
  localparam int QDEPTH   = 2;
  localparam int QAW      = $clog2(QDEPTH);

  localparam logic [CFG_IDX_W-1:0] CFG_SPACING = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK    = 1'b1;

  localparam logic [SPC_W-1:0]  SPACING_RST = 16'd2048;
  localparam logic [GAIN_W-1:0] GAIN_MAX    = 15'd16384;
  localparam logic [PHASE_W-1:0] QUARTER    = 16'd16384;

  localparam logic [31:0] SIN_A = 32'd1686629713;
  localparam logic [31:0] SIN_B = 32'd693598670;
  localparam logic [31:0] SIN_C = 32'd85569306;
  localparam logic [31:0] SIN_D = 32'd5026996;
  localparam logic [31:0] SIN_E = 32'd172272;

  typedef struct packed {
    logic [SPC_W-1:0]  spacing;
    logic [MASK_W-1:0] mask;
  } cfg_t;

  typedef struct packed {
    logic signed [D_W-1:0] du;
    logic signed [D_W-1:0] dv;
  } item_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] re;
    logic signed [ACC_W-1:0] im;
  } sum_t;

  typedef enum logic [1:0] {F_IDLE, F_WORK, F_PUSH} front_state_t;
  typedef enum logic [2:0] {B_IDLE, B_LOAD, B_RUN, B_DRAIN, B_HAND} back_state_t;
  typedef enum logic [1:0] {M_IDLE, M_SQ, M_ROOT} mag_state_t;

endpackage

>>> hdl/pabg_in_if.sv
interface pabg_in_if;
  import pabg_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [ANG_W-1:0] target_theta;
  logic signed [ANG_W-1:0] target_phi;
  logic signed [ANG_W-1:0] beam_theta;
  logic signed [ANG_W-1:0] beam_phi;

  modport source (output valid, target_theta, target_phi, beam_theta, beam_phi,
                  input ready);
  modport sink (input valid, target_theta, target_phi, beam_theta, beam_phi,
                output ready);
endinterface

>>> hdl/pabg_out_if.sv
interface pabg_out_if;
  import pabg_pkg::*;

  logic              valid;
  logic              ready;
  logic [GAIN_W-1:0] gain;

  modport source (output valid, gain, input ready);
  modport sink (input valid, gain, output ready);
endinterface

>>> hdl/pabg_sin.sv
module pabg_sin #(
  parameter int TAG_W = 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic [pabg_pkg::PHASE_W-1:0]     in_phase,
  input  logic [TAG_W-1:0]                 in_tag,
  output logic                             out_valid,
  output logic [TAG_W-1:0]                 out_tag,
  output logic signed [pabg_pkg::Q14_W-1:0] out_y
);
  import pabg_pkg::*;

  localparam int LAT = 8;

  logic [LAT-1:0]   v_r;
  logic [TAG_W-1:0] tag_r [LAT];
  logic [1:0]       q_r [LAT];
  logic [30:0]      tt_r [6];
  logic [30:0]      sq_r [4];
  logic [31:0]      r_r [4];
  logic [31:0]      s_r;
  logic signed [Q14_W-1:0] y_r;

  logic [14:0] x;
  logic [61:0] p_sq;
  logic [62:0] p_r0, p_r1, p_r2, p_r3;
  logic [62:0] p_s;
  logic [32:0] y_full;
  logic [14:0] y_mag;

  always_comb begin
    x = {1'b0, in_phase[13:0]};
    if (in_phase[14]) begin
      x = 15'd16384 - {1'b0, in_phase[13:0]};
    end
    p_sq = 62'(tt_r[0]) * 62'(tt_r[0]);
    p_r0 = 63'(sq_r[0]) * 63'(SIN_E);
    p_r1 = 63'(sq_r[1]) * 63'(r_r[0]);
    p_r2 = 63'(sq_r[2]) * 63'(r_r[1]);
    p_r3 = 63'(sq_r[3]) * 63'(r_r[2]);
    p_s  = 63'(tt_r[5]) * 63'(r_r[3]);
    y_full = (33'(s_r) + 33'd32768) >> 16;
    y_mag = (y_full > 33'd16384) ? 15'd16384 : y_full[14:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    tag_r[0] <= in_tag;
    q_r[0]   <= in_phase[15:14];
    for (int n = 1; n < LAT; n++) begin
      tag_r[n] <= tag_r[n-1];
      q_r[n]   <= q_r[n-1];
    end
    tt_r[0] <= {x, 16'b0};
    for (int n = 1; n < 6; n++) begin
      tt_r[n] <= tt_r[n-1];
    end
    sq_r[0] <= p_sq[60:30];
    for (int n = 1; n < 4; n++) begin
      sq_r[n] <= sq_r[n-1];
    end
    r_r[0] <= SIN_D - p_r0[61:30];
    r_r[1] <= SIN_C - p_r1[61:30];
    r_r[2] <= SIN_B - p_r2[61:30];
    r_r[3] <= SIN_A - p_r3[61:30];
    s_r    <= p_s[61:30];
    y_r    <= q_r[6][1] ? -$signed({1'b0, y_mag}) : $signed({1'b0, y_mag});
  end

  assign out_valid = v_r[LAT-1];
  assign out_tag   = tag_r[LAT-1];
  assign out_y     = y_r;

endmodule

>>> hdl/pabg_front.sv
module pabg_front (
  input  logic            clk,
  input  logic            rst_n,
  pabg_in_if.sink         in_chan,
  output logic            push_valid,
  input  logic            push_ready,
  output pabg_pkg::item_t push_item
);
  import pabg_pkg::*;

  localparam int CNT_W = 5;
  localparam logic [CNT_W-1:0] PH_LAST   = 5'd3;
  localparam logic [CNT_W-1:0] SIN_FIRST = 5'd8;
  localparam logic [CNT_W-1:0] SIN_LAST  = 5'd13;
  localparam logic [CNT_W-1:0] MUL_AT    = 5'd23;
  localparam logic [CNT_W-1:0] DIFF_AT   = 5'd24;

  localparam int JOB_N = 6;
  localparam logic [2:0] JOB_SIN_PT = 3'd0;
  localparam logic [2:0] JOB_COS_QT = 3'd1;
  localparam logic [2:0] JOB_SIN_QT = 3'd2;
  localparam logic [2:0] JOB_SIN_PB = 3'd3;
  localparam logic [2:0] JOB_COS_QB = 3'd4;
  localparam logic [2:0] JOB_SIN_QB = 3'd5;

  localparam logic [28:0] RECIP = 29'((64'd1 << 40) / 64'd2250);
  localparam logic [29:0] DIV   = 30'd2250;

  front_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic accept;

  logic signed [ANG_W-1:0] ang_r [4];
  logic [PHASE_W-1:0] ph_r [4];

  logic        pv1_r;
  logic [1:0]  pidx1_r;
  logic [28:0] m1_r;
  logic [17:0] q01_r;

  logic [1:0]  pidx;
  logic signed [ANG_W-1:0] a_sel;
  logic [17:0] pos;
  logic [28:0] m;
  logic [57:0] mq;
  logic [29:0] qm, rem;
  logic [17:0] q_fix;

  logic               sin_iv;
  logic [2:0]         job;
  logic [PHASE_W-1:0] sin_ph;
  logic               sin_ov;
  logic [2:0]         sin_otag;
  logic signed [Q14_W-1:0] sin_oy;
  logic signed [Q14_W-1:0] sv_r [JOB_N];

  logic signed [31:0] ut_r, ub_r, vt_r, vb_r;
  logic signed [D_W-1:0] du_r, dv_r;
  logic signed [31:0] du_full, dv_full;

  assign in_chan.ready = (state_r == F_IDLE) || (state_r == F_PUSH && push_ready);
  assign accept = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      ang_r[0] <= in_chan.target_theta;
      ang_r[1] <= in_chan.target_phi;
      ang_r[2] <= in_chan.beam_theta;
      ang_r[3] <= in_chan.beam_phi;
    end
  end

  // angle to phase: round(a * 65536 / 36000) = floor((4096*(a+36000) + 1125) / 2250)
  always_comb begin
    pidx  = cnt_r[1:0];
    a_sel = ang_r[pidx];
    pos   = 18'($signed({{2{a_sel[ANG_W-1]}}, a_sel}) + 18'sd36000);
    m     = {pos[16:0], 12'b0} + 29'd1125;
    mq    = 58'(m) * 58'(RECIP);
    qm    = 30'(q01_r) * DIV;
    rem   = {1'b0, m1_r} - qm;
    q_fix = (rem >= DIV) ? q01_r + 18'd1 : q01_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv1_r <= 1'b0;
    end else begin
      pv1_r <= (state_r == F_WORK) && (cnt_r <= PH_LAST);
    end
  end

  always_ff @(posedge clk) begin
    pidx1_r <= pidx;
    m1_r    <= m;
    q01_r   <= mq[57:40];
    if (pv1_r) begin
      ph_r[pidx1_r] <= q_fix[PHASE_W-1:0];
    end
  end

  always_comb begin
    sin_iv = (state_r == F_WORK) && (cnt_r >= SIN_FIRST) && (cnt_r <= SIN_LAST);
    job    = 3'(cnt_r - SIN_FIRST);
    unique case (job)
      JOB_SIN_PT: sin_ph = ph_r[0];
      JOB_COS_QT: sin_ph = ph_r[1] + QUARTER;
      JOB_SIN_QT: sin_ph = ph_r[1];
      JOB_SIN_PB: sin_ph = ph_r[2];
      JOB_COS_QB: sin_ph = ph_r[3] + QUARTER;
      JOB_SIN_QB: sin_ph = ph_r[3];
      default:    sin_ph = ph_r[0];
    endcase
  end

  pabg_sin #(.TAG_W(3)) u_sin (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sin_iv),
    .in_phase  (sin_ph),
    .in_tag    (job),
    .out_valid (sin_ov),
    .out_tag   (sin_otag),
    .out_y     (sin_oy)
  );

  assign du_full = ut_r - ub_r;
  assign dv_full = vt_r - vb_r;

  always_ff @(posedge clk) begin
    if (sin_ov) begin
      sv_r[sin_otag] <= sin_oy;
    end
    if (state_r == F_WORK && cnt_r == MUL_AT) begin
      ut_r <= 32'(sv_r[JOB_COS_QT]) * 32'(sv_r[JOB_SIN_PT]);
      ub_r <= 32'(sv_r[JOB_COS_QB]) * 32'(sv_r[JOB_SIN_PB]);
      vt_r <= 32'(sv_r[JOB_SIN_QT]) <<< 14;
      vb_r <= 32'(sv_r[JOB_SIN_QB]) <<< 14;
    end
    if (state_r == F_WORK && cnt_r == DIFF_AT) begin
      du_r <= du_full[D_W-1:0];
      dv_r <= dv_full[D_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    push_valid = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          state_nxt = F_WORK;
          cnt_nxt   = '0;
        end
      end
      F_WORK: begin
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == DIFF_AT) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        push_valid = 1'b1;
        if (push_ready) begin
          if (accept) begin
            state_nxt = F_WORK;
            cnt_nxt   = '0;
          end else begin
            state_nxt = F_IDLE;
          end
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  assign push_item.du = du_r;
  assign push_item.dv = dv_r;

endmodule

>>> hdl/pabg_queue.sv
module pabg_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  pabg_pkg::item_t wr_item,
  output logic            rd_valid,
  input  logic            rd_ready,
  output pabg_pkg::item_t rd_item
);
  import pabg_pkg::*;

  item_t mem [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;
  logic wr_en, rd_en;

  assign wr_ready = (cnt_r != (QAW+1)'(QDEPTH));
  assign rd_valid = (cnt_r != '0);
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;
  assign rd_item  = mem[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r <= wp_r + 1'b1;
      end
      if (rd_en) begin
        rp_r <= rp_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

>>> hdl/pabg_back.sv
module pabg_back #(
  parameter int ROWS = 8,
  parameter int COLS = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  pabg_pkg::cfg_t  cfg,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  pabg_pkg::item_t pop_item,
  output logic            sum_valid,
  input  logic            sum_ready,
  output pabg_pkg::sum_t  sum
);
  import pabg_pkg::*;

  localparam int N  = ROWS * COLS;
  localparam int KW = (N > 1) ? $clog2(N) : 1;
  localparam int JW = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int TAG_EN   = 0;
  localparam int TAG_LAST = 1;

  back_state_t state_r, state_nxt;
  item_t it_r;
  logic [PH_W-1:0] sdu_r, sdv_r, e_r, row_r;
  logic [PH_W-1:0] sdu_nxt, sdv_nxt, e_nxt, row_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [JW-1:0] j_r, j_nxt;
  logic signed [ACC_W-1:0] re_r, im_r;
  logic done_r;

  logic [PH_W-1:0] du40, dv40, ph40;
  logic [PHASE_W-1:0] el_ph, el_ph_cos;
  logic issue;
  logic [1:0] tag;
  logic c_v;
  logic [1:0] c_tag;
  logic signed [Q14_W-1:0] c_y, s_y;

  assign du40 = PH_W'(it_r.du);
  assign dv40 = PH_W'(it_r.dv);
  assign ph40 = (PH_W'(0) - e_r) + (PH_W'(1) << 23);
  assign el_ph = ph40[PH_W-1:PH_W-PHASE_W];
  assign el_ph_cos = el_ph + QUARTER;
  assign issue = (state_r == B_RUN);
  assign tag[TAG_EN]   = cfg.mask[k_r];
  assign tag[TAG_LAST] = (k_r == KW'(N-1));

  pabg_sin #(.TAG_W(2)) u_cos (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (issue),
    .in_phase  (el_ph_cos),
    .in_tag    (tag),
    .out_valid (c_v),
    .out_tag   (c_tag),
    .out_y     (c_y)
  );

  pabg_sin #(.TAG_W(2)) u_sin (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (issue),
    .in_phase  (el_ph),
    .in_tag    (tag),
    .out_valid (),
    .out_tag   (),
    .out_y     (s_y)
  );

  assign pop_ready = (state_r == B_IDLE);
  assign sum_valid = (state_r == B_HAND);
  assign sum.re    = re_r;
  assign sum.im    = im_r;

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      it_r <= pop_item;
    end
    sdu_r <= sdu_nxt;
    sdv_r <= sdv_nxt;
    e_r   <= e_nxt;
    row_r <= row_nxt;
    k_r   <= k_nxt;
    j_r   <= j_nxt;
    if (state_r == B_LOAD) begin
      re_r <= '0;
      im_r <= '0;
    end else if (c_v && c_tag[TAG_EN]) begin
      re_r <= re_r + ACC_W'(c_y);
      im_r <= im_r + ACC_W'(s_y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (c_v && c_tag[TAG_LAST]) begin
        done_r <= 1'b1;
      end else if (sum_valid && sum_ready) begin
        done_r <= 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    sdu_nxt   = sdu_r;
    sdv_nxt   = sdv_r;
    e_nxt     = e_r;
    row_nxt   = row_r;
    k_nxt     = k_r;
    j_nxt     = j_r;
    unique case (state_r)
      B_IDLE: begin
        if (pop_valid) begin
          state_nxt = B_LOAD;
        end
      end
      B_LOAD: begin
        sdu_nxt   = du40 * PH_W'(cfg.spacing);
        sdv_nxt   = dv40 * PH_W'(cfg.spacing);
        e_nxt     = '0;
        row_nxt   = '0;
        k_nxt     = '0;
        j_nxt     = '0;
        state_nxt = B_RUN;
      end
      B_RUN: begin
        k_nxt = k_r + 1'b1;
        if (j_r == JW'(COLS-1)) begin
          j_nxt   = '0;
          row_nxt = row_r + sdu_r;
          e_nxt   = row_r + sdu_r;
        end else begin
          j_nxt = j_r + 1'b1;
          e_nxt = e_r + sdv_r;
        end
        if (k_r == KW'(N-1)) begin
          state_nxt = B_DRAIN;
        end
      end
      B_DRAIN: begin
        if (done_r) begin
          state_nxt = B_HAND;
        end
      end
      B_HAND: begin
        if (sum_ready) begin
          state_nxt = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

`ifndef SYNTH
  a_last_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    c_v && c_tag[TAG_LAST] |-> state_r == B_DRAIN)
    else $error("last element left the sine pipe outside drain");
  a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !c_v)
    else $error("sine output after the last element");
  a_run_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == B_RUN |-> !done_r)
    else $error("stale done flag during element loop");
`endif

endmodule

>>> hdl/pabg_mag.sv
module pabg_mag (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           sum_valid,
  output logic           sum_ready,
  input  pabg_pkg::sum_t sum,
  pabg_out_if.source     out_chan
);
  import pabg_pkg::*;

  localparam logic [MAG_W-1:0] ROOT_BIT0 = MAG_W'(1) << (MAG_W-2);

  mag_state_t state_r, state_nxt;
  logic signed [ACC_W-1:0] re_r, im_r;
  logic [MAG_W-1:0] n_r, res_r, bit_r;
  logic [MAG_W-1:0] n_nxt, res_nxt, bit_nxt;
  logic signed [MAG_W-1:0] re_sq, im_sq;
  logic [MAG_W-1:0] trial, rnd;
  logic [GAIN_W-1:0] g;
  logic out_valid_r;
  logic [GAIN_W-1:0] gain_r;
  logic load_out;

  assign re_sq = re_r * re_r;
  assign im_sq = im_r * im_r;
  assign trial = res_r + bit_r;
  assign rnd   = (res_r + MAG_W'(32)) >> 6;
  assign g     = (rnd > MAG_W'(GAIN_MAX)) ? GAIN_MAX : rnd[GAIN_W-1:0];

  assign sum_ready = (state_r == M_IDLE);
  assign load_out  = (state_r == M_ROOT) && (bit_r == '0) &&
                     (!out_valid_r || out_chan.ready);
  assign out_chan.valid = out_valid_r;
  assign out_chan.gain  = gain_r;

  always_ff @(posedge clk) begin
    if (sum_valid && sum_ready) begin
      re_r <= sum.re;
      im_r <= sum.im;
    end
    n_r   <= n_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
    if (load_out) begin
      gain_r <= g;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= M_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    res_nxt   = res_r;
    bit_nxt   = bit_r;
    unique case (state_r)
      M_IDLE: begin
        if (sum_valid) begin
          state_nxt = M_SQ;
        end
      end
      M_SQ: begin
        n_nxt     = $unsigned(re_sq) + $unsigned(im_sq);
        res_nxt   = '0;
        bit_nxt   = ROOT_BIT0;
        state_nxt = M_ROOT;
      end
      M_ROOT: begin
        if (bit_r != '0) begin
          if (n_r >= trial) begin
            n_nxt   = n_r - trial;
            res_nxt = (res_r >> 1) + bit_r;
          end else begin
            res_nxt = res_r >> 1;
          end
          bit_nxt = bit_r >> 2;
        end else if (load_out) begin
          state_nxt = M_IDLE;
        end
      end
      default: state_nxt = M_IDLE;
    endcase
  end

endmodule

>>> hdl/planar_array_beam_gain.sv
// Planar array beam gain: each transaction on in_chan carries a target and a beam direction
// (theta, phi in hundredths of a degree); out_chan returns the array factor magnitude in
// unsigned Q.8, saturated at 16384. The front end converts the four angles and evaluates six
// sines on one pipelined polynomial unit; a two-entry queue decouples it from the back end,
// which walks the ROWS*COLS elements one per cycle through a cosine/sine pipe pair, and at
// the default 8x8 size that element loop sets the sustained rate. The magnitude square root
// runs in its own unit, overlapped with the next item. Registers: index 0 spacing ratio
// (Q4.12), index 1 element enable mask; write them only while no transaction is in flight.
module planar_array_beam_gain #(
  parameter int ROWS = 8,
  parameter int COLS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  pabg_in_if.sink                           in_chan,
  pabg_out_if.source                        out_chan,
  input  logic                              cfg_we,
  input  logic [pabg_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pabg_pkg::CFG_W-1:0]        cfg_wdata
);
  import pabg_pkg::*;

  logic [SPC_W-1:0]  spacing_r;
  logic [MASK_W-1:0] mask_r;
  cfg_t cfg;

  logic  push_valid, push_ready;
  item_t push_item;
  logic  pop_valid, pop_ready;
  item_t pop_item;
  logic  sum_valid, sum_ready;
  sum_t  sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spacing_r <= SPACING_RST;
      mask_r    <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SPACING: spacing_r <= cfg_wdata[SPC_W-1:0];
        CFG_MASK:    mask_r    <= cfg_wdata[MASK_W-1:0];
        default:     mask_r    <= mask_r;
      endcase
    end
  end

  assign cfg.spacing = spacing_r;
  assign cfg.mask    = mask_r;

  pabg_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  pabg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_item  (push_item),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_item  (pop_item)
  );

  pabg_back #(.ROWS(ROWS), .COLS(COLS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum       (sum)
  );

  pabg_mag u_mag (
    .clk       (clk),
    .rst_n     (rst_n),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum       (sum),
    .out_chan  (out_chan)
  );

endmodule
